// ===== rtl/core/kmst_pkg.sv =====
// package: shared constants, request codes and controller/datapath interface types
package kmst_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned WeightBitsDef  = 16;
  localparam int unsigned VcW            = 5;
  localparam int unsigned IdxW           = 4;
  localparam int unsigned InWeightW      = 16;
  localparam int unsigned TotalW         = 22;
  localparam logic [VcW-1:0] VcReset     = 5'd16;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqRun   = 1'b1;

  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic init;
    logic scan_clr;
    logic scan_en;
    logic pick;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic run_end;
  } status_t;

endpackage

// ===== rtl/core/kmst_ctrl.sv =====
// controller: sequences clearing, weight writes, edge scans, edge picks and the final result
module kmst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             req_type_i,
  input  kmst_pkg::status_t status_i,
  output kmst_pkg::cmd_t    cmd_o,
  output logic             busy
);

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StScan   = 5'b00100,
    StPick   = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          if (req_type_i == kmst_pkg::ReqRun) begin
            cmd_o.init     = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = StScan;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      StScan: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) state_d = StPick;
      end
      StPick: begin
        cmd_o.pick = 1'b1;
        if (status_i.run_end) begin
          state_d = StFinish;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

// ===== rtl/core/kmst_dp.sv =====
// datapath: weight store, minimum edge scan, component labels and result register
module kmst_dp #(
  parameter int unsigned MAX_VERTICES = kmst_pkg::MaxVerticesDef,
  parameter int unsigned WEIGHT_BITS  = kmst_pkg::WeightBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kmst_pkg::cmd_t                        cmd_i,
  output kmst_pkg::status_t                     status_o,
  input  logic                                  cfg_we_i,
  input  logic [kmst_pkg::VcW-1:0]              cfg_wdata_i,
  input  logic [kmst_pkg::IdxW-1:0]             row_i,
  input  logic [kmst_pkg::IdxW-1:0]             col_i,
  input  logic signed [kmst_pkg::InWeightW-1:0] weight_i,
  output logic                                  result_valid_o,
  output logic                                  edge_valid_o,
  output logic [kmst_pkg::IdxW-1:0]             edge_from_o,
  output logic [kmst_pkg::IdxW-1:0]             edge_to_o,
  output logic signed [kmst_pkg::InWeightW-1:0] edge_weight_o,
  output logic signed [kmst_pkg::TotalW-1:0]    total_weight_o,
  output logic                                  last_o,
  output logic                                  spanning_o
);

  localparam int unsigned Adj = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW  = $clog2(Adj);
  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = VW + 1;
  localparam int unsigned IW  = kmst_pkg::IdxW;
  localparam int unsigned TW  = kmst_pkg::TotalW;
  localparam int unsigned WW  = kmst_pkg::InWeightW;

  logic signed [WEIGHT_BITS-1:0] mem [Adj];

  logic [kmst_pkg::VcW-1:0] vc_q;
  logic [AW-1:0]            clr_q;
  logic [NW-1:0]            n_q, n_d;
  logic [NW-1:0]            r_q, c_q;
  logic                     s1v_q;
  logic [NW-1:0]            s1r_q, s1c_q;
  logic signed [WEIGHT_BITS-1:0] rd_q;
  logic                     bf_q;
  logic [NW-1:0]            br_q, bc_q;
  logic signed [WEIGHT_BITS-1:0] bw_q;
  logic                     hp_q;
  logic [NW-1:0]            pr_q, pc_q;
  logic signed [WEIGHT_BITS-1:0] pw_q;
  logic [VW-1:0]            label_q [MAX_VERTICES];
  logic [NW-1:0]            cnt_q;
  logic signed [TW-1:0]     tot_q;
  logic                     pend_q;
  logic [NW-1:0]            pend_r_q, pend_c_q;
  logic signed [WEIGHT_BITS-1:0] pend_w_q;
  logic signed [TW-1:0]     pend_t_q;

  logic                     issue;
  logic [AW-1:0]            raddr, waddr;
  logic                     wr_ok;
  logic                     cand, greater, better;
  logic [VW-1:0]            la, lb;
  logic                     take;
  logic [NW:0]              cnt_next;
  logic signed [TW-1:0]     tot_new;

  // effective vertex count
  always_comb begin
    if (vc_q == '0) begin
      n_d = NW'(1);
    end else if (32'(vc_q) > MAX_VERTICES) begin
      n_d = NW'(MAX_VERTICES);
    end else begin
      n_d = NW'(vc_q);
    end
  end

  assign wr_ok = (32'(row_i) < MAX_VERTICES) && (32'(col_i) < MAX_VERTICES);
  assign waddr = AW'(32'(row_i) * MAX_VERTICES + 32'(col_i));
  assign issue = cmd_i.scan_en && (r_q < n_q);
  assign raddr = AW'(32'(r_q) * MAX_VERTICES + 32'(c_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.wr_en && wr_ok) begin
      mem[waddr] <= WEIGHT_BITS'(weight_i);
    end
    rd_q <= mem[raddr];
  end

  // candidate edge from the read stage
  assign cand    = s1v_q && (s1r_q < s1c_q) && (rd_q != '0);
  assign greater = !hp_q || (rd_q > pw_q) ||
                   ((rd_q == pw_q) && ((s1r_q > pr_q) || ((s1r_q == pr_q) && (s1c_q > pc_q))));
  assign better  = !bf_q || (rd_q < bw_q);

  assign la       = label_q[br_q[VW-1:0]];
  assign lb       = label_q[bc_q[VW-1:0]];
  assign take     = bf_q && (la != lb);
  assign cnt_next = {1'b0, cnt_q} + (NW+1)'(take) + (NW+1)'(1);
  assign tot_new  = tot_q + TW'(bw_q);

  assign status_o.clr_done  = (32'(clr_q) == Adj - 1);
  assign status_o.scan_done = (r_q == n_q) && !s1v_q;
  assign status_o.run_end   = !bf_q || (cnt_next >= {1'b0, n_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q           <= kmst_pkg::VcReset;
      clr_q          <= '0;
      s1v_q          <= 1'b0;
      result_valid_o <= 1'b0;
      pend_q         <= 1'b0;
      bf_q           <= 1'b0;
      hp_q           <= 1'b0;
      cnt_q          <= '0;
      r_q            <= '0;
      c_q            <= '0;
      n_q            <= NW'(1);
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);

      s1v_q <= issue;
      if (issue) begin
        if (c_q == n_q - NW'(1)) begin
          c_q <= '0;
          r_q <= r_q + NW'(1);
        end else begin
          c_q <= c_q + NW'(1);
        end
      end
      if (cand && greater && better) bf_q <= 1'b1;

      if (cmd_i.init) begin
        n_q    <= n_d;
        cnt_q  <= '0;
        hp_q   <= 1'b0;
        pend_q <= 1'b0;
      end

      if (cmd_i.pick) begin
        hp_q <= 1'b1;
        if (take) begin
          cnt_q  <= cnt_q + NW'(1);
          pend_q <= 1'b1;
          if (pend_q) result_valid_o <= 1'b1;
        end
      end

      if (cmd_i.finish) result_valid_o <= 1'b1;

      if (cmd_i.scan_clr) begin
        r_q   <= '0;
        c_q   <= '0;
        s1v_q <= 1'b0;
        bf_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1r_q <= r_q;
    s1c_q <= c_q;
    if (cand && greater && better) begin
      br_q <= s1r_q;
      bc_q <= s1c_q;
      bw_q <= rd_q;
    end
    if (cmd_i.init) begin
      tot_q <= '0;
      for (int v = 0; v < MAX_VERTICES; v++) label_q[v] <= VW'(v);
    end
    if (cmd_i.pick) begin
      pr_q <= br_q;
      pc_q <= bc_q;
      pw_q <= bw_q;
      if (take) begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
          if (label_q[v] == lb) label_q[v] <= la;
        end
        tot_q    <= tot_new;
        pend_r_q <= br_q;
        pend_c_q <= bc_q;
        pend_w_q <= bw_q;
        pend_t_q <= tot_new;
        edge_valid_o   <= 1'b1;
        edge_from_o    <= IW'(pend_r_q);
        edge_to_o      <= IW'(pend_c_q);
        edge_weight_o  <= WW'(pend_w_q);
        total_weight_o <= pend_t_q;
        last_o         <= 1'b0;
        spanning_o     <= 1'b0;
      end
    end
    if (cmd_i.finish) begin
      edge_valid_o   <= pend_q;
      edge_from_o    <= pend_q ? IW'(pend_r_q) : '0;
      edge_to_o      <= pend_q ? IW'(pend_c_q) : '0;
      edge_weight_o  <= pend_q ? WW'(pend_w_q) : '0;
      total_weight_o <= pend_q ? pend_t_q : '0;
      last_o         <= 1'b1;
      spanning_o     <= ({1'b0, cnt_q} + (NW+1)'(1)) == {1'b0, n_q};
    end
  end

endmodule

// ===== rtl/core/minimum_spanning_tree_kruskal_unit.sv =====
// top level: kruskal minimum spanning tree unit
// usage:
//   start with req_type_i = 0 writes weight_i at (row_i, col_i); only row < col
//   is used, a zero weight means no edge. start with req_type_i = 1 runs the
//   tree search over the first vertex_count vertices (cfg_we_i / cfg_wdata_i).
//   a request is taken when start is high and busy is low.
// results:
//   each chosen edge appears for one cycle with result_valid_o high, lowest
//   weight first, ties in row-major order, with the running total. the final
//   result has last_o set and spanning_o tells if a full tree was found.
//   results cannot be stalled.
// operation:
//   a weight write leaves busy low, so writes can come back to back.
//   a run holds busy high until its last result appears, and makes one pick
//   per edge taken in weight order (chosen or skipped), plus one when the
//   edge list runs out. each pick follows a scan of the n * n weights of the
//   first n vertices through the memory's single read port.
// reset:
//   weights clear to zero by a sweep over all MAX_VERTICES * MAX_VERTICES entries
//   (256 by default) with busy high; vertex_count resets to 16.
module minimum_spanning_tree_kruskal_unit #(
  parameter int unsigned MAX_VERTICES = kmst_pkg::MaxVerticesDef,
  parameter int unsigned WEIGHT_BITS  = kmst_pkg::WeightBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cfg_we_i,
  input  logic [kmst_pkg::VcW-1:0]              cfg_wdata_i,
  input  logic                                  req_type_i,
  input  logic [kmst_pkg::IdxW-1:0]             row_i,
  input  logic [kmst_pkg::IdxW-1:0]             col_i,
  input  logic signed [kmst_pkg::InWeightW-1:0] weight_i,
  output logic                                  result_valid_o,
  output logic                                  edge_valid_o,
  output logic [kmst_pkg::IdxW-1:0]             edge_from_o,
  output logic [kmst_pkg::IdxW-1:0]             edge_to_o,
  output logic signed [kmst_pkg::InWeightW-1:0] edge_weight_o,
  output logic signed [kmst_pkg::TotalW-1:0]    total_weight_o,
  output logic                                  last_o,
  output logic                                  spanning_o
);

  kmst_pkg::cmd_t    cmd;
  kmst_pkg::status_t status;

  kmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  kmst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .weight_i       (weight_i),
    .result_valid_o (result_valid_o),
    .edge_valid_o   (edge_valid_o),
    .edge_from_o    (edge_from_o),
    .edge_to_o      (edge_to_o),
    .edge_weight_o  (edge_weight_o),
    .total_weight_o (total_weight_o),
    .last_o         (last_o),
    .spanning_o     (spanning_o)
  );

endmodule

// ===== rtl/core/kmst_checker.sv =====
// checker: port-level properties of the spanning tree unit, bound to the top level
module kmst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        req_type_i,
  input logic                        result_valid_o,
  input logic                        edge_valid_o,
  input logic [kmst_pkg::IdxW-1:0]   edge_from_o,
  input logic [kmst_pkg::IdxW-1:0]   edge_to_o,
  input logic                        last_o
);

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !edge_valid_o |-> last_o)
    else $error("empty request result without last");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result right after last");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_type_i == kmst_pkg::ReqWrite) |=> !result_valid_o)
    else $error("weight write produced a result");

  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && edge_valid_o |-> edge_from_o < edge_to_o)
    else $error("edge endpoints out of order");

endmodule

bind minimum_spanning_tree_kruskal_unit kmst_checker u_kmst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .result_valid_o (result_valid_o),
  .edge_valid_o   (edge_valid_o),
  .edge_from_o    (edge_from_o),
  .edge_to_o      (edge_to_o),
  .last_o         (last_o)
);
